[design/double_ended_queue_unit_macros.svh]
// Assertion macros shared by the deque checks.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication
`define DEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication
`define DEQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[design/deq_pkg.sv]
`default_nettype none

package deq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH  = $clog2(DEPTH);
  localparam int unsigned CNT_WIDTH   = $clog2(DEPTH + 1);
  localparam int unsigned OP_WIDTH    = 3;
  localparam int unsigned ST_WIDTH    = 2;

  // Operation codes
  typedef enum logic [OP_WIDTH-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [ST_WIDTH-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } deq_state_e;

  // Input transfer payload
  typedef struct packed {
    logic [OP_WIDTH-1:0]    operation;
    logic [VALUE_WIDTH-1:0] push_value;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    logic [ST_WIDTH-1:0]    status;
    logic [VALUE_WIDTH-1:0] front_value;
    logic [VALUE_WIDTH-1:0] back_value;
    logic [CNT_WIDTH-1:0]   item_count;
    logic                   is_empty;
  } out_t;

  // Pointer update from the operation decoder
  typedef struct packed {
    status_e               status;
    logic [ADDR_WIDTH-1:0] head;
    logic [CNT_WIDTH-1:0]  count;
    logic                  rev;
    logic                  wr_en;
    logic [ADDR_WIDTH-1:0] wr_addr;
    logic [ADDR_WIDTH-1:0] front_addr;
    logic [ADDR_WIDTH-1:0] back_addr;
  } upd_t;

endpackage

`default_nettype wire

[design/double_ended_queue_unit.sv]
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | in_data_i  (operation, push_value)
// out     | output    | out_valid_o/out_ready_i| out_data_o (status, front/back, count, empty)
//
// An operation runs as accept with pointer update and ring write, ring read of both
// end slots, then load of the output register. The ring RAM's registered read ports
// place the read between the write and the result.
// Reset clears head, count, reversed flag and the sequencer; ring contents stay as is.
// A stalled output holds the sequencer in its last step; input is taken only when idle.
`default_nettype none

module double_ended_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  deq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::out_t out_data_o
);

  import deq_pkg::*;

  deq_state_e state_q, state_d;

  logic [ADDR_WIDTH-1:0]  head_q, head_d;
  logic [CNT_WIDTH-1:0]   count_q, count_d;
  logic                   rev_q, rev_d;
  logic                   out_valid_q, out_valid_d;
  logic [ST_WIDTH-1:0]    status_q;
  out_t                   out_q, out_d;

  logic                   accept;
  logic                   ram_re;
  logic                   out_load;
  logic [VALUE_WIDTH-1:0] rdata_a;
  logic [VALUE_WIDTH-1:0] rdata_b;
  upd_t                   upd;

  assign accept = in_valid_i && in_ready_o;

  deq_ptr u_ptr (
    .operation_i (in_data_i.operation),
    .head_i      (head_q),
    .count_i     (count_q),
    .rev_i       (rev_q),
    .upd_o       (upd)
  );

  deq_ram #(
    .Width (VALUE_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (accept && upd.wr_en),
    .waddr_i   (upd.wr_addr),
    .wdata_i   (in_data_i.push_value),
    .re_i      (ram_re),
    .raddr_a_i (upd.front_addr),
    .raddr_b_i (upd.back_addr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_OUT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Queue state update on accept
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rev_d   = rev_q;
    if (accept) begin
      head_d  = upd.head;
      count_d = upd.count;
      rev_d   = upd.rev;
    end
  end

  // Result assembly; an empty queue shows zero values
  always_comb begin
    out_d             = '0;
    out_d.status      = status_q;
    out_d.item_count  = count_q;
    out_d.is_empty    = (count_q == '0);
    if (count_q != '0) begin
      out_d.front_value = rev_q ? rdata_b : rdata_a;
      out_d.back_value  = rev_q ? rdata_a : rdata_b;
    end
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= upd.status;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[design/deq_ram.sv]
`default_nettype none

module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[design/deq_ptr.sv]
`default_nettype none

module deq_ptr (
  input  logic [deq_pkg::OP_WIDTH-1:0]   operation_i,
  input  logic [deq_pkg::ADDR_WIDTH-1:0] head_i,
  input  logic [deq_pkg::CNT_WIDTH-1:0]  count_i,
  input  logic                           rev_i,
  output deq_pkg::upd_t                  upd_o
);

  import deq_pkg::*;

  localparam logic [CNT_WIDTH:0]     SumDepth = (CNT_WIDTH + 1)'(DEPTH);
  localparam logic [CNT_WIDTH-1:0]   CntFull  = CNT_WIDTH'(DEPTH);
  localparam logic [ADDR_WIDTH-1:0]  LastSlot = ADDR_WIDTH'(DEPTH - 1);

  // Ring slot base + off; off stays below DEPTH except for the back slot of an empty queue
  function automatic logic [ADDR_WIDTH-1:0] slot_add(input logic [ADDR_WIDTH-1:0] base,
                                                     input logic [CNT_WIDTH-1:0]  off);
    logic [CNT_WIDTH:0] sum;
    sum = (CNT_WIDTH + 1)'(base) + (CNT_WIDTH + 1)'(off);
    if (sum >= SumDepth) begin
      sum = sum - SumDepth;
    end
    return sum[ADDR_WIDTH-1:0];
  endfunction

  function automatic logic [ADDR_WIDTH-1:0] slot_dec(input logic [ADDR_WIDTH-1:0] base);
    return (base == '0) ? LastSlot : base - ADDR_WIDTH'(1);
  endfunction

  logic at_front_push;
  logic at_front_pop;

  assign at_front_push = (operation_i == OP_PUSH_FRONT) != rev_i;
  assign at_front_pop  = (operation_i == OP_POP_FRONT) != rev_i;

  // Operation decode and pointer update
  always_comb begin
    upd_o         = '0;
    upd_o.status  = ST_DONE;
    upd_o.head    = head_i;
    upd_o.count   = count_i;
    upd_o.rev     = rev_i;
    upd_o.wr_en   = 1'b0;
    upd_o.wr_addr = head_i;
    unique case (operation_i) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (count_i == CntFull) begin
          upd_o.status = ST_PUSH_FULL;
        end else begin
          upd_o.wr_en = 1'b1;
          upd_o.count = count_i + CNT_WIDTH'(1);
          if (at_front_push) begin
            upd_o.head    = slot_dec(head_i);
            upd_o.wr_addr = slot_dec(head_i);
          end else begin
            upd_o.wr_addr = slot_add(head_i, count_i);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count_i == '0) begin
          upd_o.status = ST_POP_EMPTY;
        end else begin
          upd_o.count = count_i - CNT_WIDTH'(1);
          if (at_front_pop) begin
            upd_o.head = slot_add(head_i, CNT_WIDTH'(1));
          end
        end
      end
      OP_REVERSE: begin
        upd_o.rev = !rev_i;
      end
      default: begin
        // unused codes leave the queue alone
      end
    endcase
    // physical end slots of the current contents
    upd_o.front_addr = head_i;
    upd_o.back_addr  = slot_add(head_i, count_i - CNT_WIDTH'(1));
  end

endmodule

`default_nettype wire

[design/deq_checker.sv]
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module deq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input deq_pkg::out_t out_data_o
);

  import deq_pkg::*;

  // Empty flag agrees with the count
  `DEQ_ASSERT_IMP(a_empty_count, out_valid_o, out_data_o.is_empty == (out_data_o.item_count == '0))

  // An empty queue reports zero end values
  `DEQ_ASSERT_IMP(a_empty_zero, out_valid_o && out_data_o.is_empty, (out_data_o.front_value == '0) && (out_data_o.back_value == '0))

  // Error codes match the fill level
  `DEQ_ASSERT_IMP(a_status_level, out_valid_o, ((out_data_o.status != ST_POP_EMPTY) || out_data_o.is_empty) && ((out_data_o.status != ST_PUSH_FULL) || (out_data_o.item_count == CNT_WIDTH'(DEPTH))))

  // One operation in flight: no new transfer right after one is taken
  `DEQ_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // A stalled result holds
  `DEQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

`default_nettype wire

[tb/sv/double_ended_queue_unit_tb.sv]
`default_nettype none

module double_ended_queue_unit_tb;
  import deq_pkg::*;

  // Pacing styles for the sender and the receiver
  typedef enum int {
    PACE_STEADY,
    PACE_LIGHT,
    PACE_HEAVY
  } pace_e;

  // Unused operation codes, ignored by the block
  localparam logic [OP_WIDTH-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_UNUSED_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t  in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;

  double_ended_queue_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // Shadow deque state
  logic [VALUE_WIDTH-1:0] slot_mem [DEPTH];
  int unsigned head_slot = 0;
  int unsigned fill_count = 0;
  logic flipped = 1'b0;

  out_t expected_results[$];
  int error_count = 0;

  pace_e src_pace = PACE_STEADY;
  pace_e sink_pace = PACE_STEADY;
  int burst_left = 0;
  int hold_left = 0;

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    error_count++;
  endtask

  // Apply one operation to the shadow deque and return the queue view after it
  function automatic out_t deque_apply(in_t item);
    out_t res;
    logic at_phys_front;
    logic [VALUE_WIDTH-1:0] phys_front;
    logic [VALUE_WIDTH-1:0] phys_back;
    res = '0;
    res.status = ST_DONE;
    phys_front = '0;
    phys_back = '0;
    case (item.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          res.status = ST_PUSH_FULL;
        end else begin
          at_phys_front = (item.operation == OP_PUSH_FRONT) != flipped;
          if (at_phys_front) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot_mem[ADDR_WIDTH'(head_slot)] = item.push_value;
          end else begin
            slot_mem[ADDR_WIDTH'((head_slot + fill_count) % DEPTH)] = item.push_value;
          end
          fill_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_count == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          at_phys_front = (item.operation == OP_POP_FRONT) != flipped;
          if (at_phys_front) head_slot = (head_slot + 1) % DEPTH;
          fill_count--;
        end
      end
      OP_REVERSE: flipped = !flipped;
      default: ;
    endcase
    if (fill_count != 0) begin
      phys_front = slot_mem[ADDR_WIDTH'(head_slot)];
      phys_back = slot_mem[ADDR_WIDTH'((head_slot + fill_count - 1) % DEPTH)];
    end
    res.front_value = flipped ? phys_back : phys_front;
    res.back_value = flipped ? phys_front : phys_back;
    res.item_count = CNT_WIDTH'(fill_count);
    res.is_empty = (fill_count == 0);
    return res;
  endfunction

  // Result check first, then prediction for a transfer accepted at this edge
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(out_data_o.front_value), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
          if (out_data_o.front_value !== want.front_value)
            report_mismatch("front_value", 64'(out_data_o.front_value),
                            64'(want.front_value));
          if (out_data_o.back_value !== want.back_value)
            report_mismatch("back_value", 64'(out_data_o.back_value),
                            64'(want.back_value));
          if (out_data_o.item_count !== want.item_count)
            report_mismatch("item_count", 64'(out_data_o.item_count),
                            64'(want.item_count));
          if (out_data_o.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(out_data_o.is_empty), 64'(want.is_empty));
        end
      end
      if (in_valid && in_ready_o) expected_results.push_back(deque_apply(in_data));
    end
  end

  // Receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= 1'b1;
      case (sink_pace)
        PACE_LIGHT: if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 3);
        PACE_HEAVY: if ($urandom_range(0, 1) == 0) hold_left = $urandom_range(1, 12);
        default: ;
      endcase
    end
  end

  // Send one operation; bursts and gaps depend on the sender pace
  task automatic send_op(logic [OP_WIDTH-1:0] op, logic [VALUE_WIDTH-1:0] value);
    in_t item;
    int gap;
    item.operation = op;
    item.push_value = value;
    if (src_pace != PACE_STEADY && burst_left == 0) begin
      gap = (src_pace == PACE_HEAVY) ? $urandom_range(1, 6) : $urandom_range(1, 2);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = (src_pace == PACE_HEAVY) ? $urandom_range(1, 4) : $urandom_range(4, 16);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  // Pops and reverse on an empty queue, unused codes
  task automatic test_empty_cases();
    send_op(OP_POP_FRONT, 32'h1234_5678);
    send_op(OP_POP_BACK, '1);
    send_op(OP_REVERSE, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_REVERSE, '1);
    for (int c = int'(OP_UNUSED_LO); c <= int'(OP_UNUSED_HI); c++)
      send_op(OP_WIDTH'(c), pick_value());
  endtask

  // Value extremes at both ends, across a reverse
  task automatic test_value_extremes();
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_BACK, 32'hA5A5_5A5A);
    send_op(OP_REVERSE, '0);
    send_op(OP_PUSH_FRONT, 32'h8000_0001);
    send_op(OP_UNUSED_HI, '1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REVERSE, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
  endtask

  // Drain, fill past full, reverse, pop half, push one, drain past empty
  task automatic test_fill_drain(int rounds);
    for (int r = 0; r < rounds; r++) begin
      repeat (DEPTH + 1) send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
      repeat (DEPTH + 2)
        send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
      send_op(OP_REVERSE, pick_value());
      repeat (DEPTH / 2) send_op(OP_POP_FRONT, pick_value());
      send_op(OP_PUSH_BACK, pick_value());
      repeat (DEPTH / 2 + 2)
        send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
    end
  endtask

  // Random mix; push_pct sets the share of pushes among push and pop
  task automatic test_random_mix(int count, int push_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2)
        send_op(OP_WIDTH'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), pick_value());
      else if (r < 8)
        send_op(OP_REVERSE, pick_value());
      else if ($urandom_range(0, 99) < push_pct)
        send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
      else
        send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_empty_cases();
    test_value_extremes();

    src_pace = PACE_HEAVY;
    sink_pace = PACE_LIGHT;
    test_fill_drain(3);
    src_pace = PACE_STEADY;
    sink_pace = PACE_STEADY;
    test_fill_drain(2);

    src_pace = PACE_LIGHT;
    sink_pace = PACE_HEAVY;
    test_random_mix(450, 65);
    src_pace = PACE_HEAVY;
    sink_pace = PACE_LIGHT;
    test_random_mix(450, 35);
    src_pace = PACE_STEADY;
    sink_pace = PACE_STEADY;
    test_random_mix(300, 50);
    src_pace = PACE_LIGHT;
    sink_pace = PACE_LIGHT;
    test_random_mix(350, 55);

    @(negedge clk_i);
    in_valid <= 1'b0;
    sink_pace = PACE_STEADY;

    // Drain and let the pipeline settle
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
